/* hw/rtl/ierm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ierm_pkg: shared definitions for the ICMP echo reply matcher
// Item codes, verdict codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package ierm_pkg;

	localparam int DEF_TARGET_SLOTS = 16;
	localparam int DEF_MAX_PACKET   = 1024;

	localparam int MODE_W    = 2;
	localparam int VERDICT_W = 3;
	localparam int OSLOT_W   = 4;
	localparam int ID_W      = 16;
	localparam int CFG_IDX_W = 2;

	// item kinds on the slave side
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	// verdicts
	localparam logic [VERDICT_W-1:0] V_MATCH     = 3'd0;
	localparam logic [VERDICT_W-1:0] V_SHORT     = 3'd1;
	localparam logic [VERDICT_W-1:0] V_NOT_REPLY = 3'd2;
	localparam logic [VERDICT_W-1:0] V_BAD_ID    = 3'd3;
	localparam logic [VERDICT_W-1:0] V_BAD_SEQ   = 3'd4;
	localparam logic [VERDICT_W-1:0] V_NO_TARGET = 3'd5;
	localparam logic [VERDICT_W-1:0] V_QUERY     = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_ID    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USED_SLOTS = 2'd1;

	localparam int          MIN_IP_LEN      = 20;
	localparam int          ICMP_HDR_LEN    = 8;
	localparam logic [7:0]  ICMP_ECHO_REPLY = 8'h00;
	localparam logic [15:0] EXP_SEQ         = 16'h0001;
	localparam int          SRC_ADDR_OFS    = 12;

	// header bytes fetched after the last byte: type, id (2), seq (2), source (4)
	localparam int FETCH_STEPS = 9;

	// check steps on the shared compare unit
	localparam logic [1:0] CK_TYPE = 2'd0;
	localparam logic [1:0] CK_ID   = 2'd1;
	localparam logic [1:0] CK_SEQ  = 2'd2;

	typedef struct packed {
		logic wr;   // write address, clear flag at write index
		logic set;  // set flag at read index
	} tbl_ctl_t;

endpackage

/* hw/rtl/ierm_pkt_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ierm_pkt_buf: packet byte store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ierm_pkt_buf #(
	parameter int DEPTH = ierm_pkg::DEF_MAX_PACKET,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import ierm_pkg::*;

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ierm_tgt_tbl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ierm_tgt_tbl: target address table with reached flags
// Addresses in a memory with registered read; flags in flops, cleared at reset.
// ----------------------------------------------------------------------------
module ierm_tgt_tbl #(
	parameter int TARGET_SLOTS = ierm_pkg::DEF_TARGET_SLOTS,
	parameter int SLOT_W       = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ierm_pkg::tbl_ctl_t      ctl,
	input  logic [SLOT_W-1:0]       waddr,
	input  logic [31:0]             wdata,
	input  logic [SLOT_W-1:0]       raddr,
	output logic [31:0]             rdata,
	output logic [TARGET_SLOTS-1:0] flags
);
	import ierm_pkg::*;

	logic [31:0]             addr_mem_q [TARGET_SLOTS];
	logic [31:0]             rdata_q;
	logic [TARGET_SLOTS-1:0] flags_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			addr_mem_q[waddr] <= wdata;
		end
		rdata_q <= addr_mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			if (ctl.wr) begin
				flags_q[waddr] <= 1'b0;
			end
			if (ctl.set) begin
				flags_q[raddr] <= 1'b1;
			end
		end
	end

	assign rdata = rdata_q;
	assign flags = flags_q;

endmodule

/* hw/rtl/icmp_echo_reply_matcher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_reply_matcher_top: ICMP echo reply matcher
// Checks received IPv4 packets for echo replies and marks targets reached.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream s_*: tuser carries the item kind (write slot, packet byte,
//    query slot); tlast marks the final byte of a packet.
//  - Master stream m_*: one result item per query and per finished packet;
//    tuser carries the verdict.
//  - cfg_*: register writes (echo id, used slot count), always ready; write
//    only while the block is idle.
//  - Slot writes and non-final packet bytes stream at one per clock unless a
//    result waits on a stalled receiver. A query answers in the next cycle.
//  - After the final byte a sequencer checks the packet using a single read
//    port of the packet store and one shared 32-bit comparator: length
//    check, header fetch, compares of type, id and sequence that stop at the
//    first mismatch, then a read and compare of each used table slot in turn.
//    s_tready is low throughout.
//  - s_tready also drops while a result waits and m_tready is low, so a
//    stalled receiver holds back new items; no result is ever lost.
//  - Reset clears all reached flags, the byte count and both registers.
// ----------------------------------------------------------------------------
module icmp_echo_reply_matcher_top #(
	parameter int TARGET_SLOTS = ierm_pkg::DEF_TARGET_SLOTS,
	parameter int MAX_PACKET   = ierm_pkg::DEF_MAX_PACKET
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // slot[3:0], target_address[35:4], data_byte[43:36]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	input  logic        s_tlast,   // last
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // matched_slot[3:0], reached[4]
	output logic [2:0]  m_tuser,   // verdict[2:0]
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ierm_pkg::*;

	localparam int SLOT_W = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
	localparam int LIM_W  = $clog2(TARGET_SLOTS + 1);
	localparam int PA_W   = $clog2(MAX_PACKET);
	localparam int CNT_W  = $clog2(MAX_PACKET + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LEN    = 6'b000010,
		S_FETCH  = 6'b000100,
		S_CHECK  = 6'b001000,
		S_SEARCH = 6'b010000,
		S_SCMP   = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [5:0]         hl_q;
	logic [3:0]         fc_q;
	logic [1:0]         ck_q;
	logic [LIM_W-1:0]   si_q;
	logic [ID_W-1:0]    echo_id_q;
	logic [4:0]         used_q;
	logic               m_tvalid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [OSLOT_W-1:0] oslot_q;
	logic               reached_q;
	logic [71:0]        hdr_q;

	logic [3:0]         in_slot;
	logic [31:0]        in_addr;
	logic [7:0]         in_byte;
	logic               accept;
	logic               slot_ok;
	logic               byte_room;
	logic               finish;
	logic               res_vld;
	logic [VERDICT_W-1:0] res_verdict;
	logic [OSLOT_W-1:0] res_slot;
	logic               res_reached;
	logic [LIM_W-1:0]   lim;
	logic [CNT_W-1:0]   min_len;

	logic               pb_we;
	logic [PA_W-1:0]    pb_raddr;
	logic [7:0]         pb_rdata;
	logic [7:0]         fetch_ofs;

	tbl_ctl_t           tbl_ctl;
	logic [31:0]        tbl_rdata;
	logic [TARGET_SLOTS-1:0] tbl_flags;

	logic [31:0]        cmp_a, cmp_b;
	logic               cmp_eq;

	assign in_slot = s_tdata[3:0];
	assign in_addr = s_tdata[35:4];
	assign in_byte = s_tdata[43:36];

	assign s_tready  = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign slot_ok   = (int'(in_slot) < TARGET_SLOTS);
	assign byte_room = (int'(cnt_q) < MAX_PACKET);
	assign lim       = (int'(used_q) < TARGET_SLOTS) ? LIM_W'(used_q) : LIM_W'(TARGET_SLOTS);
	assign min_len   = (CNT_W'(hl_q) + CNT_W'(ICMP_HDR_LEN) > CNT_W'(MIN_IP_LEN)) ?
	                   CNT_W'(hl_q) + CNT_W'(ICMP_HDR_LEN) : CNT_W'(MIN_IP_LEN);

	// fetch order: type, id hi/lo, seq hi/lo, source address bytes 12..15
	always_comb begin
		if (fc_q == 4'd0) begin
			fetch_ofs = {2'b00, hl_q};
		end else if (fc_q < 4'd5) begin
			fetch_ofs = {2'b00, hl_q} + 8'd3 + {4'd0, fc_q};
		end else begin
			fetch_ofs = 8'(SRC_ADDR_OFS - 5) + {4'd0, fc_q};
		end
	end
	assign pb_raddr = PA_W'(fetch_ofs);

	// shared comparator
	assign cmp_eq = (cmp_a == cmp_b);

	always_comb begin
		state_d     = state_q;
		finish      = 1'b0;
		res_vld     = 1'b0;
		res_verdict = V_MATCH;
		res_slot    = '0;
		res_reached = 1'b0;
		pb_we       = 1'b0;
		tbl_ctl     = '0;
		cmp_a       = '0;
		cmp_b       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (s_tuser == MODE_WRITE) begin
						tbl_ctl.wr = slot_ok;
					end else if (s_tuser == MODE_QUERY) begin
						res_vld     = 1'b1;
						res_verdict = V_QUERY;
						res_slot    = in_slot;
						res_reached = slot_ok && tbl_flags[SLOT_W'(in_slot)];
					end else if (s_tuser == MODE_BYTE) begin
						pb_we = byte_room;
						if (s_tlast) begin
							state_d = S_LEN;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LEN: begin
				if (cnt_q < min_len) begin
					res_vld     = 1'b1;
					res_verdict = V_SHORT;
					finish      = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				if (fc_q == 4'(FETCH_STEPS)) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (ck_q)
					CK_TYPE: begin
						cmp_a       = {24'd0, hdr_q[71:64]};
						cmp_b       = {24'd0, ICMP_ECHO_REPLY};
						res_verdict = V_NOT_REPLY;
					end
					CK_ID: begin
						cmp_a       = {16'd0, hdr_q[63:48]};
						cmp_b       = {16'd0, echo_id_q};
						res_verdict = V_BAD_ID;
					end
					CK_SEQ: begin
						cmp_a       = {16'd0, hdr_q[47:32]};
						cmp_b       = {16'd0, EXP_SEQ};
						res_verdict = V_BAD_SEQ;
					end
					default: begin
						cmp_a       = '0;
						cmp_b       = '0;
						res_verdict = V_BAD_SEQ;
					end
				endcase
				if (!cmp_eq) begin
					res_vld = 1'b1;
					finish  = 1'b1;
					state_d = S_IDLE;
				end else if (ck_q == CK_SEQ) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (si_q >= lim) begin
					res_vld     = 1'b1;
					res_verdict = V_NO_TARGET;
					finish      = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				cmp_a = tbl_rdata;
				cmp_b = hdr_q[31:0];
				if (cmp_eq) begin
					tbl_ctl.set = 1'b1;
					res_vld     = 1'b1;
					res_verdict = V_MATCH;
					res_slot    = OSLOT_W'(si_q);
					res_reached = 1'b1;
					finish      = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			hl_q       <= '0;
			fc_q       <= '0;
			ck_q       <= CK_TYPE;
			si_q       <= '0;
			echo_id_q  <= '0;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pb_we) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '0) begin
					hl_q <= {in_byte[3:0], 2'b00};
				end
			end
			if (finish) begin
				cnt_q <= '0;
				hl_q  <= '0;
			end
			if (state_q == S_LEN) begin
				fc_q <= '0;
			end else if (state_q == S_FETCH) begin
				fc_q <= fc_q + 1'b1;
			end
			if (state_q == S_FETCH) begin
				ck_q <= CK_TYPE;
			end else if (state_q == S_CHECK) begin
				ck_q <= ck_q + 1'b1;
			end
			if (state_q == S_CHECK) begin
				si_q <= '0;
			end else if (state_q == S_SCMP) begin
				si_q <= si_q + 1'b1;
			end
			if (res_vld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ECHO_ID) begin
					echo_id_q <= cfg_data;
				end else if (cfg_index == REG_USED_SLOTS) begin
					used_q <= cfg_data[4:0];
				end
			end
		end
	end

	// header bytes arrive in the cycle after their read
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH && fc_q != 4'd0) begin
			hdr_q <= {hdr_q[63:0], pb_rdata};
		end
		if (res_vld) begin
			verdict_q <= res_verdict;
			oslot_q   <= res_slot;
			reached_q <= res_reached;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = verdict_q;
	assign m_tdata  = {3'b000, reached_q, oslot_q};

	ierm_pkt_buf #(
		.DEPTH (MAX_PACKET),
		.AW    (PA_W)
	) u_pkt_buf (
		.clk   (clk),
		.we    (pb_we),
		.waddr (cnt_q[PA_W-1:0]),
		.wdata (in_byte),
		.raddr (pb_raddr),
		.rdata (pb_rdata)
	);

	ierm_tgt_tbl #(
		.TARGET_SLOTS (TARGET_SLOTS),
		.SLOT_W       (SLOT_W)
	) u_tgt_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.waddr  (SLOT_W'(in_slot)),
		.wdata  (in_addr),
		.raddr  (si_q[SLOT_W-1:0]),
		.rdata  (tbl_rdata),
		.flags  (tbl_flags)
	);

endmodule

/* sim/icmp_echo_reply_matcher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_reply_matcher_top_tb: self-checking bench for the echo reply matcher
// A table of directed cases (reset values, slot writes, every verdict, short,
// long and overlong packets) is followed by phases of random traffic under
// several register settings. Results are checked against pinned row values or
// an in-bench model of target table and packet checks. Both streams idle at random.
// ----------------------------------------------------------------------------
module icmp_echo_reply_matcher_top_tb;
	import ierm_pkg::*;

	localparam int          SLOTS         = DEF_TARGET_SLOTS;
	localparam int          PKT_MAX       = DEF_MAX_PACKET;
	localparam int          IDLE_PCT      = 7;
	localparam int          SETTLE_CYCLES = 64;
	localparam int          DRAIN_LIMIT   = 100000;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          PHASE_ITEMS   = 165;
	localparam int          RESULT_GOAL   = 48;
	localparam logic [1:0]  MODE_SPARE      = 2'd3;
	localparam logic [1:0]  REG_UNMAPPED_LO = 2'd2;
	localparam logic [1:0]  REG_UNMAPPED_HI = 2'd3;

	typedef struct packed {
		logic [2:0] verdict;
		logic [3:0] slot;
		logic       reached;
	} echo_res_t;

	typedef enum logic [2:0] {
		ROW_WRITE, ROW_QUERY, ROW_PACKET, ROW_SPARE, ROW_REG, ROW_FILL
	} row_op_e;

	// slot doubles as register index and addr as register data for ROW_REG
	typedef struct packed {
		row_op_e     op;
		logic [3:0]  slot;
		logic [31:0] addr;
		logic [7:0]  b0;
		logic [11:0] len;
		logic [7:0]  icmp_type;
		logic [15:0] id;
		logic [15:0] seq;
		logic        pinned;
		logic [2:0]  v;
		logic [3:0]  ps;
		logic        r;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [0:29] = '{
		'{ROW_QUERY,  4'd0,  32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b1, V_QUERY, 4'd0, 1'b0},
		'{ROW_QUERY,  4'd15, 32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b1, V_QUERY, 4'd15, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0,         8'h45, 12'd28,   8'h00, 16'h0000, 16'h0001,
			1'b1, V_NO_TARGET, 4'd0, 1'b0},
		'{ROW_REG,    {2'b0, REG_ECHO_ID},     32'h0000_FFFF, 8'h00, 12'd0, 8'h00, 16'h0,
			16'h0, 1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_REG,    {2'b0, REG_USED_SLOTS},  32'd16,        8'h00, 12'd0, 8'h00, 16'h0,
			16'h0, 1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_REG,    {2'b0, REG_UNMAPPED_LO}, 32'h0,         8'h00, 12'd0, 8'h00, 16'h0,
			16'h0, 1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_REG,    {2'b0, REG_UNMAPPED_HI}, 32'h0,         8'h00, 12'd0, 8'h00, 16'h0,
			16'h0, 1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_FILL,   4'd0,  32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_WRITE,  4'd0,  32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_WRITE,  4'd15, 32'hFFFF_FFFF, 8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'hFFFF_FFFF, 8'h45, 12'd28,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_MATCH, 4'd15, 1'b1},
		'{ROW_QUERY,  4'd15, 32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b1, V_QUERY, 4'd15, 1'b1},
		'{ROW_PACKET, 4'd0,  32'h0,         8'h45, 12'd28,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_MATCH, 4'd0, 1'b1},
		'{ROW_PACKET, 4'd0,  32'h0,         8'h45, 12'd19,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_SHORT, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0003, 8'h4F, 12'd67,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_SHORT, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0003, 8'h4F, 12'd68,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_MATCH, 4'd3, 1'b1},
		'{ROW_PACKET, 4'd0,  32'hFFFF_FFFF, 8'h45, 12'd28,   8'h08, 16'hFFFF, 16'h0001,
			1'b1, V_NOT_REPLY, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'hFFFF_FFFF, 8'h45, 12'd28,   8'h00, 16'h0000, 16'h0001,
			1'b1, V_BAD_ID, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'hFFFF_FFFF, 8'h45, 12'd28,   8'h00, 16'hFFFF, 16'h0100,
			1'b1, V_BAD_SEQ, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'hFFFF_FFFF, 8'h45, 12'd28,   8'h00, 16'hFFFF, 16'hFFFF,
			1'b1, V_BAD_SEQ, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'hC0A8_0101, 8'h45, 12'd28,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_NO_TARGET, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0007, 8'h00, 12'd20,   8'h00, 16'hFFFF, 16'h0001,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0008, 8'h42, 12'd20,   8'h00, 16'hFFFF, 16'h0001,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_SPARE,  4'd15, 32'hFFFF_FFFF, 8'hFF, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_WRITE,  4'd15, 32'h0A00_0003, 8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_QUERY,  4'd15, 32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b1, V_QUERY, 4'd15, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0003, 8'h45, 12'd28,   8'h00, 16'hFFFF, 16'h0001,
			1'b1, V_MATCH, 4'd3, 1'b1},
		'{ROW_PACKET, 4'd0,  32'h0A00_0005, 8'h45, 12'd1100, 8'h00, 16'hFFFF, 16'h0001,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_PACKET, 4'd0,  32'h0A00_0006, 8'h46, 12'd1024, 8'h00, 16'hFFFF, 16'h0001,
			1'b0, V_MATCH, 4'd0, 1'b0},
		'{ROW_QUERY,  4'd5,  32'h0,         8'h00, 12'd0,    8'h00, 16'h0000, 16'h0000,
			1'b0, V_MATCH, 4'd0, 1'b0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // slot[3:0], target_address[35:4], data_byte[43:36]
	logic [1:0]  s_tuser   = '0;   // mode[1:0]
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // matched_slot[3:0], reached[4]
	logic [2:0]  m_tuser;          // verdict[2:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	// model state
	logic [31:0] tgt_addr    [SLOTS];
	logic        tgt_reached [SLOTS];
	logic [7:0]  pkt_mem     [PKT_MAX];
	int unsigned pkt_len;
	int unsigned hdr_len;
	logic [15:0] cur_echo_id;
	logic [4:0]  cur_used;

	echo_res_t   pending_res [$];
	logic [7:0]  frame_buf [0:2047];
	echo_res_t   pin_res;
	bit          pin_on;
	bit          calm;
	int unsigned items_sent;
	int unsigned results_due;
	int unsigned fail_count;
	int unsigned cycle_count;

	icmp_echo_reply_matcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic note_fail(input string what, input echo_res_t want, input echo_res_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: want verdict %0d slot %0d reached %0b, got verdict %0d slot %0d reached %0b",
				$time, what, want.verdict, want.slot, want.reached,
				got.verdict, got.slot, got.reached);
	endtask

	always @(posedge clk) begin : result_check
		echo_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[3:0], m_tdata[4]};
			if (pending_res.size() == 0) begin
				note_fail("unexpected result", 'x, got);
			end else begin
				if (got !== pending_res[0])
					note_fail("result mismatch", pending_res[0], got);
				void'(pending_res.pop_front());
			end
		end
	end

	// table update and packet checks for one accepted item
	task automatic echo_predict(input logic [1:0] mode, input logic [3:0] slot,
			input logic [31:0] addr, input logic [7:0] dbyte, input logic lst,
			output bit has_res, output echo_res_t res);
		int unsigned lim;
		logic [31:0] src;
		has_res = 1'b0;
		res = '0;
		case (mode)
			MODE_WRITE: begin
				tgt_addr[slot] = addr;
				tgt_reached[slot] = 1'b0;
			end
			MODE_QUERY: begin
				has_res = 1'b1;
				res = '{V_QUERY, slot, tgt_reached[slot]};
			end
			MODE_BYTE: begin
				if (pkt_len < PKT_MAX) begin
					if (pkt_len == 0)
						hdr_len = dbyte[3:0] * 4;
					pkt_mem[pkt_len] = dbyte;
					pkt_len++;
				end
				if (lst) begin
					has_res = 1'b1;
					res = '{V_NO_TARGET, 4'd0, 1'b0};
					if (pkt_len < MIN_IP_LEN || pkt_len < hdr_len + ICMP_HDR_LEN) begin
						res.verdict = V_SHORT;
					end else if (pkt_mem[hdr_len] != ICMP_ECHO_REPLY) begin
						res.verdict = V_NOT_REPLY;
					end else if ({pkt_mem[hdr_len+4], pkt_mem[hdr_len+5]} != cur_echo_id) begin
						res.verdict = V_BAD_ID;
					end else if ({pkt_mem[hdr_len+6], pkt_mem[hdr_len+7]} != EXP_SEQ) begin
						res.verdict = V_BAD_SEQ;
					end else begin
						src = {pkt_mem[SRC_ADDR_OFS], pkt_mem[SRC_ADDR_OFS+1],
							pkt_mem[SRC_ADDR_OFS+2], pkt_mem[SRC_ADDR_OFS+3]};
						lim = (cur_used > SLOTS) ? SLOTS : cur_used;
						// first matching slot wins
						for (int i = 0; i < lim && res.verdict == V_NO_TARGET; i++) begin
							if (tgt_addr[i] == src) begin
								tgt_reached[i] = 1'b1;
								res = '{V_MATCH, i[3:0], 1'b1};
							end
						end
					end
					pkt_len = 0;
					hdr_len = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_item(input logic [1:0] mode, input logic [3:0] slot,
			input logic [31:0] addr, input logic [7:0] dbyte, input logic lst);
		bit has_res;
		echo_res_t res;
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {4'h0, dbyte, addr, slot};
		s_tlast  = lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		echo_predict(mode, slot, addr, dbyte, lst, has_res, res);
		if (has_res) begin
			if (pin_on) begin
				res = pin_res;
				pin_on = 1'b0;
			end
			pending_res.push_back(res);
			results_due++;
		end
		if (mode != MODE_SPARE)
			items_sent++;
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [11:0] len,
			input logic [7:0] icmp_type, input logic [15:0] id, input logic [15:0] seq,
			input logic [31:0] src, input bit noisy);
		int unsigned hl;
		int unsigned n;
		for (n = 0; n < len; n++)
			frame_buf[n] = 8'($urandom);
		frame_buf[0] = b0;
		hl = b0[3:0] * 4;
		{frame_buf[12], frame_buf[13], frame_buf[14], frame_buf[15]} = src;
		// ICMP header goes last so it wins where it overlaps the source address
		frame_buf[hl] = icmp_type;
		{frame_buf[hl+4], frame_buf[hl+5]} = id;
		{frame_buf[hl+6], frame_buf[hl+7]} = seq;
		for (n = 0; n < len; n++) begin
			if (noisy && $urandom_range(99) < 3)
				push_item($urandom_range(1) ? MODE_QUERY : MODE_SPARE, 4'($urandom),
					$urandom, 8'($urandom), 1'($urandom));
			push_item(MODE_BYTE, 4'($urandom), $urandom, frame_buf[n], n == len - 1);
		end
	endtask

	// drop valid, wait for outstanding results, then let the sequencer finish
	task automatic settle();
		int unsigned w;
		@(negedge clk);
		s_tvalid = 1'b0;
		for (w = 0; w < DRAIN_LIMIT && pending_res.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ECHO_ID:    cur_echo_id = val;
			REG_USED_SLOTS: cur_used = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : stimulus
		dir_row_t    row;
		logic [31:0] addr_pool [8];
		logic [15:0] ph_echo;
		logic [15:0] ph_used;
		logic [3:0]  ihl;
		logic [7:0]  b0;
		logic [11:0] plen;
		int unsigned base;
		int unsigned pick;
		int unsigned lpick;
		int unsigned big_left;
		int unsigned phase_goal;
		int unsigned results_base;
		logic [31:0] src;

		for (int i = 0; i < SLOTS; i++)
			tgt_reached[i] = 1'b0;
		pkt_len = 0;
		hdr_len = 0;
		cur_echo_id = '0;
		cur_used = '0;
		pin_on = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		results_due = 0;
		fail_count = 0;
		cycle_count = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < $size(DIR_ROWS); r++) begin
			row = DIR_ROWS[r];
			pin_on = row.pinned;
			pin_res = '{row.v, row.ps, row.r};
			case (row.op)
				ROW_REG: begin
					settle();
					write_reg(row.slot[1:0], row.addr[15:0]);
				end
				ROW_FILL: begin
					for (int k = 0; k < SLOTS; k++)
						push_item(MODE_WRITE, k[3:0], {28'h0A00000, k[3:0]},
							8'($urandom), 1'($urandom));
				end
				ROW_WRITE:
					push_item(MODE_WRITE, row.slot, row.addr, 8'($urandom), 1'($urandom));
				ROW_QUERY:
					push_item(MODE_QUERY, row.slot, $urandom, 8'($urandom), 1'($urandom));
				ROW_SPARE:
					push_item(MODE_SPARE, row.slot, row.addr, row.b0, 1'b1);
				default:
					send_packet(row.b0, row.len, row.icmp_type, row.id, row.seq,
						row.addr, 1'b0);
			endcase
		end
		pin_on = 1'b0;

		for (int i = 0; i < 8; i++)
			addr_pool[i] = $urandom;
		big_left = 3;
		results_base = results_due;

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			calm = (ph == 2);
			case (ph)
				0: begin ph_echo = 16'h0000; ph_used = 16'd0; end
				1: begin ph_echo = 16'hFFFF; ph_used = 16'd16; end
				2: begin ph_echo = 16'($urandom); ph_used = 16'd31; end
				3: begin ph_echo = 16'($urandom); ph_used = 16'd1; end
				4: begin ph_echo = 16'h0000; ph_used = 16'd17; end
				default: begin
					ph_echo = 16'($urandom);
					ph_used = 16'($urandom_range(SLOTS));
				end
			endcase
			write_reg(REG_ECHO_ID, ph_echo);
			write_reg(REG_USED_SLOTS, ph_used);
			if (ph == 5) begin
				write_reg(REG_UNMAPPED_LO, 16'($urandom));
				write_reg(REG_UNMAPPED_HI, 16'($urandom));
			end
			phase_goal = items_sent + PHASE_ITEMS;
			while (items_sent < phase_goal ||
					(ph == 7 && results_due - results_base < RESULT_GOAL)) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					// mostly well-formed echo replies with random content
					ihl = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom);
					b0 = {($urandom_range(9) == 0) ? 4'($urandom) : 4'h4, ihl};
					base = (ihl * 4 + ICMP_HDR_LEN > MIN_IP_LEN) ?
						ihl * 4 + ICMP_HDR_LEN : MIN_IP_LEN;
					lpick = $urandom_range(99);
					if (lpick < 8) begin
						plen = 12'($urandom_range(base - 1, 1));
					end else if (lpick < 9 && big_left > 0) begin
						plen = 12'($urandom_range(1100, PKT_MAX + 1));
						big_left--;
					end else begin
						plen = 12'(base + $urandom_range(24));
					end
					case ($urandom_range(3))
						0: src = $urandom;
						1: src = addr_pool[$urandom_range(7)];
						default: src = tgt_addr[$urandom_range(SLOTS - 1)];
					endcase
					send_packet(b0, plen,
						($urandom_range(99) < 90) ? ICMP_ECHO_REPLY : 8'($urandom_range(255, 1)),
						($urandom_range(99) < 90) ? cur_echo_id : 16'($urandom),
						($urandom_range(99) < 90) ? EXP_SEQ : 16'($urandom),
						src, 1'b1);
				end else if (pick < 60) begin
					send_packet(8'($urandom), 12'($urandom_range(40, 1)), 8'($urandom),
						16'($urandom), 16'($urandom), $urandom, 1'b1);
				end else if (pick < 75) begin
					push_item(MODE_WRITE, 4'($urandom),
						($urandom_range(99) < 60) ? addr_pool[$urandom_range(7)] : $urandom,
						8'($urandom), 1'($urandom));
				end else if (pick < 92) begin
					push_item(MODE_QUERY, 4'($urandom), $urandom, 8'($urandom), 1'($urandom));
				end else begin
					push_item(MODE_SPARE, 4'($urandom), $urandom, 8'($urandom), 1'($urandom));
				end
			end
		end

		calm = 1'b0;
		settle();
		if (pending_res.size() != 0)
			note_fail("result missing", pending_res[0], 'x);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/ierm_pkg.sv
hw/rtl/ierm_pkt_buf.sv
hw/rtl/ierm_tgt_tbl.sv
hw/rtl/icmp_echo_reply_matcher_top.sv
sim/icmp_echo_reply_matcher_top_tb.sv
